@@ rtl/core/eirltv_pkg.sv @@
// shared types, constants and codes for the eir length-tag-value record checker
// no dependencies; used by the top, classify and walker modules in rtl/core
package eirltv_pkg;

  localparam int BUFFER_BYTES_DEFAULT = 256;
  localparam int QUEUE_DEPTH_DEFAULT  = 2;

  localparam int BYTE_W    = 8;
  localparam int TAG_W     = 5;
  localparam int LEN_W     = 9;
  localparam int MAP_W     = 33;
  localparam int TAG_IDX_W = 6;
  localparam int STATUS_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [TAG_IDX_W-1:0] VENDOR_BIT = TAG_IDX_W'(32);

  // register reset values
  localparam logic [TAG_W-1:0]  VALID_TAG_LOW_RST  = TAG_W'(1);
  localparam logic [TAG_W-1:0]  VALID_TAG_HIGH_RST = TAG_W'(15);
  localparam logic [BYTE_W-1:0] VENDOR_TAG_RST     = BYTE_W'(255);
  localparam logic [LEN_W-1:0]  MAX_SIG_LEN_RST    = LEN_W'(240);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALID_TAG_LOW  = 2'd0,
    REG_VALID_TAG_HIGH = 2'd1,
    REG_VENDOR_TAG     = 2'd2,
    REG_MAX_SIG_LEN    = 2'd3
  } reg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_UNKNOWN_TAG = 3'd1,
    ST_DUPLICATE   = 3'd2,
    ST_OVERRUN     = 3'd3,
    ST_TOO_LONG    = 3'd4
  } status_t;

  // classified byte, from front to walker
  typedef struct packed {
    logic [BYTE_W-1:0]    data_byte;
    logic                 last_byte;
    logic                 is_zero;
    logic                 tag_known;
    logic [TAG_IDX_W-1:0] tag_idx;
  } item_t;

  typedef struct packed {
    status_t          status;
    logic [LEN_W-1:0] kept_length;
    logic [LEN_W-1:0] significant_length;
    logic [MAP_W-1:0] tag_presence;
  } result_t;

endpackage

@@ rtl/core/eir_ltv_record_checker_top.sv @@
// eir length-tag-value record checker: one byte per cycle in while full is low, one result per buffer out
// a byte accepted into the byte queue is walked from the queue head; a last byte's result
//   enters the result queue when that byte is walked and is readable once empty goes low
// throughput: one byte per cycle, except that a last byte waits while the result queue is full
// reset: synchronous active-high rst clears queues and walk, loads register reset values
// depends on eirltv_pkg, eirltv_classify, eirltv_fifo, eirltv_walker
module eir_ltv_record_checker_top #(
  parameter int BUFFER_BYTES = eirltv_pkg::BUFFER_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH  = eirltv_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // input side, queue style
  input  logic                              push,
  output logic                              full,
  input  logic [eirltv_pkg::BYTE_W-1:0]     data_byte,
  input  logic                              last_byte,
  // result side, queue style
  output logic                              empty,
  input  logic                              pop,
  output logic [eirltv_pkg::STATUS_W-1:0]   status,
  output logic [eirltv_pkg::LEN_W-1:0]      kept_length,
  output logic [eirltv_pkg::LEN_W-1:0]      significant_length,
  output logic [eirltv_pkg::MAP_W-1:0]      tag_presence,
  // register write port
  input  logic                              cfg_write,
  input  logic [eirltv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [eirltv_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int ITEM_W = $bits(eirltv_pkg::item_t);
  localparam int RES_W  = $bits(eirltv_pkg::result_t);

  // configuration registers
  logic [eirltv_pkg::TAG_W-1:0]  valid_tag_low;
  logic [eirltv_pkg::TAG_W-1:0]  valid_tag_high;
  logic [eirltv_pkg::BYTE_W-1:0] vendor_tag;
  logic [eirltv_pkg::LEN_W-1:0]  max_significant_length;

  eirltv_pkg::item_t   front_item;
  eirltv_pkg::item_t   back_item;
  eirltv_pkg::result_t walk_res;
  eirltv_pkg::result_t out_res;
  logic [ITEM_W-1:0]   mid_pop_data;
  logic [RES_W-1:0]    out_pop_data;
  logic                mid_empty;
  logic                item_take;
  logic                res_push;
  logic                res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_tag_low          <= eirltv_pkg::VALID_TAG_LOW_RST;
      valid_tag_high         <= eirltv_pkg::VALID_TAG_HIGH_RST;
      vendor_tag             <= eirltv_pkg::VENDOR_TAG_RST;
      max_significant_length <= eirltv_pkg::MAX_SIG_LEN_RST;
    end else if (cfg_write) begin
      unique case (eirltv_pkg::reg_index_t'(cfg_index))
        eirltv_pkg::REG_VALID_TAG_LOW:  valid_tag_low  <= cfg_data[eirltv_pkg::TAG_W-1:0];
        eirltv_pkg::REG_VALID_TAG_HIGH: valid_tag_high <= cfg_data[eirltv_pkg::TAG_W-1:0];
        eirltv_pkg::REG_VENDOR_TAG:     vendor_tag     <= cfg_data[eirltv_pkg::BYTE_W-1:0];
        eirltv_pkg::REG_MAX_SIG_LEN:    max_significant_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: tag classification of every byte as it arrives
  eirltv_classify u_classify (
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .valid_tag_low  (valid_tag_low),
    .valid_tag_high (valid_tag_high),
    .vendor_tag     (vendor_tag),
    .item           (front_item)
  );

  // queue between front and walker; its full flag is the input full
  eirltv_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_item),
    .full      (full),
    .pop       (item_take),
    .pop_data  (mid_pop_data),
    .empty     (mid_empty)
  );

  assign back_item = eirltv_pkg::item_t'(mid_pop_data);

  // back: record walk, one classified byte per cycle while the queue holds one and no last byte waits for result room
  eirltv_walker #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_walker (
    .clk                    (clk),
    .rst                    (rst),
    .item_valid             (!mid_empty),
    .item                   (back_item),
    .item_take              (item_take),
    .res_full               (res_full),
    .max_significant_length (max_significant_length),
    .res_push               (res_push),
    .res                    (walk_res)
  );

  // result queue parts the walker from the consumer
  eirltv_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (walk_res),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (out_pop_data),
    .empty     (empty)
  );

  assign out_res            = eirltv_pkg::result_t'(out_pop_data);
  assign status             = out_res.status;
  assign kept_length        = out_res.kept_length;
  assign significant_length = out_res.significant_length;
  assign tag_presence       = out_res.tag_presence;

endmodule

@@ rtl/core/eirltv_fifo.sv @@
// small first-in first-out queue with full and empty flags
// depends on nothing; used for the classified byte queue and the result queue
module eirltv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/eirltv_classify.sv @@
// front end: classifies each incoming byte as a possible tag
// depends on eirltv_pkg
module eirltv_classify (
  input  logic [eirltv_pkg::BYTE_W-1:0] data_byte,
  input  logic                          last_byte,
  input  logic [eirltv_pkg::TAG_W-1:0]  valid_tag_low,
  input  logic [eirltv_pkg::TAG_W-1:0]  valid_tag_high,
  input  logic [eirltv_pkg::BYTE_W-1:0] vendor_tag,
  output eirltv_pkg::item_t             item
);

  logic                         small_tag;
  logic [eirltv_pkg::TAG_W-1:0] tag5;
  logic                         in_range;

  assign small_tag = (data_byte[eirltv_pkg::BYTE_W-1:eirltv_pkg::TAG_W] == '0);
  assign tag5      = data_byte[eirltv_pkg::TAG_W-1:0];
  assign in_range  = small_tag && (tag5 >= valid_tag_low) && (tag5 <= valid_tag_high);

  always_comb begin
    item.data_byte = data_byte;
    item.last_byte = last_byte;
    item.is_zero   = (data_byte == '0);
    // vendor tag always maps to the extra presence bit
    if (data_byte == vendor_tag) begin
      item.tag_known = 1'b1;
      item.tag_idx   = eirltv_pkg::VENDOR_BIT;
    end else begin
      item.tag_known = in_range;
      item.tag_idx   = eirltv_pkg::TAG_IDX_W'(tag5);
    end
  end

endmodule

@@ rtl/core/eirltv_walker.sv @@
// back end: walks the length-tag-value records and builds the result
// depends on eirltv_pkg
module eirltv_walker #(
  parameter int BUFFER_BYTES = eirltv_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  eirltv_pkg::item_t            item,
  output logic                         item_take,
  input  logic                         res_full,
  input  logic [eirltv_pkg::LEN_W-1:0] max_significant_length,
  output logic                         res_push,
  output eirltv_pkg::result_t          res
);

  localparam int POS_W = $clog2(BUFFER_BYTES + 1);
  localparam int LEN_W = eirltv_pkg::LEN_W;
  localparam int MAP_W = eirltv_pkg::MAP_W;
  localparam int IDX_W = eirltv_pkg::TAG_IDX_W;

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_TAG    = 2'd1,
    PH_VALUE  = 2'd2,
    PH_ENDED  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNKNOWN   = 2'd1,
    ERR_DUPLICATE = 2'd2
  } err_t;

  phase_t           phase, phase_next;
  err_t             first_error, first_error_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [LEN_W-1:0] next_record_start, next_record_start_next;
  logic [LEN_W-1:0] current_record_start, current_record_start_next;
  logic [LEN_W-1:0] cut_position, cut_position_next;
  logic [MAP_W-1:0] presence_map, presence_map_next;
  logic             pend_valid, pend_valid_next;
  logic [IDX_W-1:0] pend_idx, pend_idx_next;

  logic             in_buffer;
  logic [LEN_W-1:0] pos_ext;
  logic [LEN_W-1:0] pos_plus1;
  logic             record_done;
  logic [LEN_W-1:0] sig_len;
  eirltv_pkg::result_t res_next;

  // a last byte waits until the result queue has room
  assign item_take = item_valid && (!item.last_byte || !res_full);

  assign in_buffer   = (byte_position < POS_W'(BUFFER_BYTES));
  assign pos_ext     = LEN_W'(byte_position);
  assign pos_plus1   = pos_ext + LEN_W'(1);
  assign record_done = (next_record_start == pos_plus1);

  always_comb begin
    phase_next                = phase;
    first_error_next          = first_error;
    byte_position_next        = byte_position;
    next_record_start_next    = next_record_start;
    current_record_start_next = current_record_start;
    cut_position_next         = cut_position;
    presence_map_next         = presence_map;
    pend_valid_next           = pend_valid;
    pend_idx_next             = pend_idx;

    if (in_buffer) begin
      unique case (phase)
        PH_LENGTH: begin
          if (item.is_zero) begin
            phase_next             = PH_ENDED;
            next_record_start_next = pos_ext;
          end else begin
            current_record_start_next = pos_ext;
            next_record_start_next    = pos_plus1 + LEN_W'(item.data_byte);
            phase_next                = PH_TAG;
          end
        end
        PH_TAG: begin
          if (first_error == ERR_NONE) begin
            if (!item.tag_known) begin
              first_error_next  = ERR_UNKNOWN;
              cut_position_next = current_record_start;
            end else if (presence_map[item.tag_idx]) begin
              first_error_next  = ERR_DUPLICATE;
              cut_position_next = current_record_start;
            end else begin
              pend_valid_next = 1'b1;
              pend_idx_next   = item.tag_idx;
            end
          end
          phase_next = record_done ? PH_LENGTH : PH_VALUE;
        end
        PH_VALUE: begin
          if (record_done) begin
            phase_next = PH_LENGTH;
          end
        end
        PH_ENDED: begin
        end
        default: begin
        end
      endcase
      // tag bit counts only once its record closes inside the buffer
      if (phase_next == PH_LENGTH && pend_valid_next) begin
        presence_map_next = presence_map | (MAP_W'(1) << pend_idx_next);
        pend_valid_next   = 1'b0;
      end
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  assign sig_len = next_record_start_next;

  always_comb begin
    res_next.significant_length = sig_len;
    res_next.tag_presence       = presence_map_next;
    priority if (sig_len > max_significant_length) begin
      res_next.status       = eirltv_pkg::ST_TOO_LONG;
      res_next.kept_length  = '0;
      res_next.tag_presence = '0;
    end else if (first_error_next == ERR_UNKNOWN) begin
      res_next.status      = eirltv_pkg::ST_UNKNOWN_TAG;
      res_next.kept_length = cut_position_next;
    end else if (first_error_next == ERR_DUPLICATE) begin
      res_next.status      = eirltv_pkg::ST_DUPLICATE;
      res_next.kept_length = cut_position_next;
    end else if (sig_len > LEN_W'(byte_position_next)) begin
      res_next.status      = eirltv_pkg::ST_OVERRUN;
      res_next.kept_length = current_record_start_next;
    end else begin
      res_next.status      = eirltv_pkg::ST_OK;
      res_next.kept_length = sig_len;
    end
  end

  assign res_push = item_take && item.last_byte;
  assign res      = res_next;

  always_ff @(posedge clk) begin
    if (rst || res_push) begin
      phase                <= PH_LENGTH;
      first_error          <= ERR_NONE;
      byte_position        <= '0;
      next_record_start    <= '0;
      current_record_start <= '0;
      cut_position         <= '0;
      presence_map         <= '0;
      pend_valid           <= 1'b0;
      pend_idx             <= '0;
    end else if (item_take) begin
      phase                <= phase_next;
      first_error          <= first_error_next;
      byte_position        <= byte_position_next;
      next_record_start    <= next_record_start_next;
      current_record_start <= current_record_start_next;
      cut_position         <= cut_position_next;
      presence_map         <= presence_map_next;
      pend_valid           <= pend_valid_next;
      pend_idx             <= pend_idx_next;
    end
  end

endmodule

@@ tb/sv/tb.sv @@
// self-checking testbench for eir_ltv_record_checker_top: random and directed response buffers
// a byte-level record walk predicts each buffer's result; depends on eirltv_pkg and the rtl core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUFFER_BYTES = eirltv_pkg::BUFFER_BYTES_DEFAULT;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 4;

  localparam int BYTE_W     = eirltv_pkg::BYTE_W;
  localparam int TAG_W      = eirltv_pkg::TAG_W;
  localparam int LEN_W      = eirltv_pkg::LEN_W;
  localparam int MAP_W      = eirltv_pkg::MAP_W;
  localparam int TAG_IDX_W  = eirltv_pkg::TAG_IDX_W;
  localparam int STATUS_W   = eirltv_pkg::STATUS_W;
  localparam int CFG_IDX_W  = eirltv_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = eirltv_pkg::CFG_DATA_W;

  typedef eirltv_pkg::result_t result_t;
  typedef eirltv_pkg::status_t status_t;

  // one byte of a response buffer as it goes to the push side
  typedef struct packed {
    logic [BYTE_W-1:0] octet;
    logic              last;
  } eir_byte_t;

  typedef logic [BYTE_W-1:0] byte_list_t[$];

  // where the record walk stands within the current buffer
  typedef enum logic [1:0] {
    WALK_LENGTH,
    WALK_TAG,
    WALK_VALUE,
    WALK_DONE
  } walk_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  push = 1'b0;
  logic                  full;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic                  last_byte = 1'b0;
  logic                  empty;
  logic                  pop = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [LEN_W-1:0]      kept_length;
  logic [LEN_W-1:0]      significant_length;
  logic [MAP_W-1:0]      tag_presence;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  eir_ltv_record_checker_top u_top (
    .clk                (clk),
    .rst                (rst),
    .push               (push),
    .full               (full),
    .data_byte          (data_byte),
    .last_byte          (last_byte),
    .empty              (empty),
    .pop                (pop),
    .status             (status),
    .kept_length        (kept_length),
    .significant_length (significant_length),
    .tag_presence       (tag_presence),
    .cfg_write          (cfg_write),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // bytes waiting for the driver, and buffer results still owed by the block
  eir_byte_t byte_q[$];
  result_t   report_q[$];

  // copy of the register file, kept in step with every write
  logic [TAG_W-1:0]  cfg_tag_low  = eirltv_pkg::VALID_TAG_LOW_RST;
  logic [TAG_W-1:0]  cfg_tag_high = eirltv_pkg::VALID_TAG_HIGH_RST;
  logic [BYTE_W-1:0] cfg_vendor   = eirltv_pkg::VENDOR_TAG_RST;
  logic [LEN_W-1:0]  cfg_max_len  = eirltv_pkg::MAX_SIG_LEN_RST;

  // walk state of the buffer in progress
  logic [LEN_W-1:0]     walk_pos       = '0;
  logic [LEN_W-1:0]     walk_next      = '0;
  walk_phase_t          walk_phase     = WALK_LENGTH;
  logic [MAP_W-1:0]     walk_map       = '0;
  status_t              walk_error     = eirltv_pkg::ST_OK;
  logic [LEN_W-1:0]     walk_cut       = '0;
  logic [LEN_W-1:0]     walk_rec_start = '0;
  logic                 tag_held       = 1'b0;
  logic [TAG_IDX_W-1:0] tag_held_idx   = '0;

  // run bookkeeping
  bit      idle_en = 1'b1;
  int      mismatches = 0;
  int      bytes_queued = 0;
  int      buffers_done = 0;
  int      settings_used = 1;
  int      status_seen[5];
  int      send_gap = 0;
  int      pop_gap = 0;
  int      cycle_count = 0;
  eir_byte_t on_bus;
  result_t   oldest;

  // advance the record walk by one accepted byte; on a last byte, owe one result
  function automatic void walk_byte(input eir_byte_t it);
    logic [LEN_W-1:0]     pos;
    logic [TAG_IDX_W-1:0] idx;
    logic                 known;
    result_t              rep;
    if (walk_pos < BUFFER_BYTES) begin
      pos = walk_pos;
      case (walk_phase)
        WALK_LENGTH: begin
          if (it.octet == '0) begin
            // zero length byte: significant data ends here
            walk_phase = WALK_DONE;
            walk_next  = pos;
          end else begin
            walk_rec_start = pos;
            walk_next      = LEN_W'(pos + it.octet + 1);
            walk_phase     = WALK_TAG;
          end
        end
        WALK_TAG: begin
          // once an error is latched the tags are no longer looked at
          if (walk_error == eirltv_pkg::ST_OK) begin
            known = 1'b1;
            idx   = '0;
            if (it.octet == cfg_vendor) begin
              idx = eirltv_pkg::VENDOR_BIT;
            end else if (it.octet <= 31 && it.octet >= cfg_tag_low &&
                         it.octet <= cfg_tag_high) begin
              idx = TAG_IDX_W'(it.octet);
            end else begin
              known = 1'b0;
            end
            if (!known) begin
              walk_error = eirltv_pkg::ST_UNKNOWN_TAG;
              walk_cut   = walk_rec_start;
            end else if (walk_map[idx]) begin
              walk_error = eirltv_pkg::ST_DUPLICATE;
              walk_cut   = walk_rec_start;
            end else begin
              tag_held     = 1'b1;
              tag_held_idx = idx;
            end
          end
          walk_phase = (walk_next == pos + 1) ? WALK_LENGTH : WALK_VALUE;
        end
        WALK_VALUE: begin
          if (walk_next == pos + 1) walk_phase = WALK_LENGTH;
        end
        default: ;
      endcase
      // a tag only counts once its record closes inside the buffer
      if (walk_phase == WALK_LENGTH && tag_held) begin
        walk_map[tag_held_idx] = 1'b1;
        tag_held = 1'b0;
      end
      walk_pos = pos + 1;
    end
    if (!it.last) return;

    rep.significant_length = walk_next;
    if (walk_next > cfg_max_len) begin
      rep.status       = eirltv_pkg::ST_TOO_LONG;
      rep.kept_length  = '0;
      rep.tag_presence = '0;
    end else if (walk_error != eirltv_pkg::ST_OK) begin
      rep.status       = walk_error;
      rep.kept_length  = walk_cut;
      rep.tag_presence = walk_map;
    end else if (walk_next > walk_pos) begin
      rep.status       = eirltv_pkg::ST_OVERRUN;
      rep.kept_length  = walk_rec_start;
      rep.tag_presence = walk_map;
    end else begin
      rep.status       = eirltv_pkg::ST_OK;
      rep.kept_length  = walk_next;
      rep.tag_presence = walk_map;
    end
    report_q.push_back(rep);
    status_seen[rep.status]++;
    buffers_done++;

    // ready for the next buffer
    walk_pos       = '0;
    walk_next      = '0;
    walk_phase     = WALK_LENGTH;
    walk_map       = '0;
    walk_error     = eirltv_pkg::ST_OK;
    walk_cut       = '0;
    walk_rec_start = '0;
    tag_held       = 1'b0;
  endfunction

  function automatic void check_field(input string name, input logic [MAP_W-1:0] want,
                                      input logic [MAP_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // queue one buffer, flagging its final byte
  task automatic add_buffer(input byte_list_t bytes);
    eir_byte_t it;
    foreach (bytes[i]) begin
      it.octet = bytes[i];
      it.last  = (i == bytes.size() - 1);
      byte_q.push_back(it);
    end
    bytes_queued += bytes.size();
  endtask

  // mostly well-formed record chains with random content; the rest is noise,
  // truncated chains and long buffers; min_len forces a chain of at least that length
  task automatic queue_random_buffer(input int min_len);
    byte_list_t bytes;
    int kind;
    int limit;
    int max_rec;
    int rec_len;
    int rec_at;
    int pick;
    kind    = $urandom_range(0, 99);
    rec_at  = -1;
    rec_len = 0;
    if (min_len > 0) begin
      limit   = min_len;
      max_rec = 40;
    end else if (kind < 70) begin
      limit   = $urandom_range(0, 24);
      max_rec = 5;
    end else if (kind < 92) begin
      limit   = 0;
      max_rec = 1;
    end else begin
      limit   = $urandom_range(60, 250);
      max_rec = 40;
    end
    while (bytes.size() < limit) begin
      rec_len = $urandom_range(1, max_rec);
      rec_at  = bytes.size();
      bytes.push_back(BYTE_W'(rec_len));
      // tags: mostly from the valid range, some vendor, some anything
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        bytes.push_back(BYTE_W'($urandom_range(cfg_tag_low, cfg_tag_high)));
      end else if (pick < 17) begin
        bytes.push_back(cfg_vendor);
      end else begin
        bytes.push_back(BYTE_W'($urandom));
      end
      repeat (rec_len - 1) bytes.push_back(BYTE_W'($urandom));
    end
    if (min_len == 0 && kind >= 70 && kind < 92) begin
      // raw noise
      repeat ($urandom_range(1, 16)) bytes.push_back(BYTE_W'($urandom));
    end else begin
      case ($urandom_range(0, 3))
        2: begin
          // zero length terminator followed by ignored padding
          bytes.push_back('0);
          repeat ($urandom_range(0, 3)) bytes.push_back(BYTE_W'($urandom));
        end
        3: begin
          // chop the tail of the last record so that it overruns the buffer
          if (rec_at >= 0) repeat ($urandom_range(1, rec_len)) void'(bytes.pop_back());
        end
        default: ;
      endcase
    end
    if (bytes.size() == 0) bytes.push_back(BYTE_W'($urandom));
    add_buffer(bytes);
  endtask

  task automatic run_random(input int budget);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < budget) queue_random_buffer(0);
  endtask

  // wait for the queue to drain and every owed result to arrive, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    while (byte_q.size() != 0 || push || report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back; only called while the block is idle
  task automatic program_registers(input logic [TAG_W-1:0] lo, input logic [TAG_W-1:0] hi,
                                   input logic [BYTE_W-1:0] vend,
                                   input logic [LEN_W-1:0] max_len);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= eirltv_pkg::REG_VALID_TAG_LOW;
    cfg_data  <= CFG_DATA_W'(lo);
    @(posedge clk);
    cfg_index <= eirltv_pkg::REG_VALID_TAG_HIGH;
    cfg_data  <= CFG_DATA_W'(hi);
    @(posedge clk);
    cfg_index <= eirltv_pkg::REG_VENDOR_TAG;
    cfg_data  <= CFG_DATA_W'(vend);
    @(posedge clk);
    cfg_index <= eirltv_pkg::REG_MAX_SIG_LEN;
    cfg_data  <= CFG_DATA_W'(max_len);
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_tag_low  = lo;
    cfg_tag_high = hi;
    cfg_vendor   = vend;
    cfg_max_len  = max_len;
    settings_used++;
  endtask

  // free-running clock, 10 ns period
  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends the run here
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // push-side driver: a transaction completes at an edge with push high and full low;
  // the byte is predicted at that edge, and the next one (or a gap) is set up
  always @(posedge clk) begin
    if (rst) begin
      push     <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) walk_byte(on_bus);
      if (push && full) begin
        // back-pressure: hold the byte on the bus
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (byte_q.size() != 0) begin
        on_bus = byte_q.pop_front();
        push      <= 1'b1;
        data_byte <= on_bus.octet;
        last_byte <= on_bus.last;
        if (idle_en && $urandom_range(0, 19) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        push <= 1'b0;
      end
    end
  end

  // pop-side monitor: every completed transaction is checked against the oldest owed result
  always @(posedge clk) begin
    if (rst) begin
      pop     <= 1'b0;
      pop_gap = 0;
    end else begin
      if (pop && !empty) begin
        if (report_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none owed, expected nothing, actual status %0d",
                   $time, status);
        end else begin
          oldest = report_q.pop_front();
          check_field("status", MAP_W'(oldest.status), MAP_W'(status));
          check_field("kept_length", MAP_W'(oldest.kept_length), MAP_W'(kept_length));
          check_field("significant_length", MAP_W'(oldest.significant_length),
                      MAP_W'(significant_length));
          check_field("tag_presence", oldest.tag_presence, tag_presence);
        end
      end
      // random stall bursts on the result side
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (idle_en && $urandom_range(0, 15) == 0) pop_gap = $urandom_range(1, 15);
      end
    end
  end

  // stimulus sequence, one register setting per phase
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed buffers under the reset register values
    add_buffer('{8'h00});                               // empty buffer, max byte edge 0
    add_buffer('{8'h02, 8'h01, 8'hAA, 8'h02, 8'h01, 8'h55}); // same tag twice
    add_buffer('{8'h02, 8'hFF, 8'h07, 8'h00, 8'hFF});   // vendor tag, bytes after terminator
    add_buffer('{8'h03, 8'h10, 8'h01, 8'h02, 8'h01, 8'h05}); // unknown tag, walk continues
    add_buffer('{8'hFF, 8'h03, 8'h09});                 // walk far past the length limit
    add_buffer('{8'h02, 8'h04, 8'h09, 8'h05, 8'h06});   // last record runs off the end
    add_buffer('{8'h01, 8'h00});                        // tag below the valid range
    run_random(180);
    wait_idle();

    // full valid range, vendor tag inside it, no length limit; one oversized buffer
    program_registers(5'd0, 5'd31, 8'd0, 9'd511);
    run_random(150);
    queue_random_buffer(270);
    wait_idle();

    // single-tag range at the top, vendor tag equal to it
    program_registers(5'd31, 5'd31, 8'd31, 9'd255);
    run_random(150);
    wait_idle();

    // empty valid range: only the vendor tag gets through; tight length limit
    program_registers(5'd20, 5'd5, 8'd200, 9'd40);
    run_random(150);
    wait_idle();

    // zero length limit: anything past a leading terminator is thrown away
    program_registers(5'd0, 5'd0, 8'd255, 9'd0);
    run_random(60);
    wait_idle();

    // closing phase: random setting, no idling on either side
    idle_en = 1'b0;
    program_registers(TAG_W'($urandom), TAG_W'($urandom), BYTE_W'($urandom),
                      LEN_W'($urandom_range(20, 511)));
    run_random(200);
    wait_idle();
    repeat (10) @(posedge clk);

    if (report_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived, expected 0 owed, actual %0d",
               $time, report_q.size(), report_q.size());
    end
    $display("walked %0d bytes in %0d buffers across %0d register settings",
             bytes_queued, buffers_done, settings_used);
    $display("outcomes: ok %0d, unknown tag %0d, duplicate %0d, overrun %0d, too long %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
